@@ design/dzam_pkg.sv @@
// Shared types and constants for the deadzone axis mapper.
// Used by dzam_ctrl, dzam_datapath and deadzone_axis_mapper_core; no dependencies.
package dzam_pkg;

    // Fixed field widths
    localparam int IN_DATA_W   = 16;    // sample field
    localparam int READING_W   = 16;    // signed reading
    localparam int BOUND_W     = 18;    // signed deadzone bounds
    localparam int OUT_DATA_W  = 56;    // reading, floor, ceiling, zero padded to bytes
    localparam int OUT_USER_W  = 2;     // changed, calibrating
    localparam int ADC_BITS_W  = 5;
    localparam int BEND_LOW_W  = 16;
    localparam int BEND_HIGH_W = 15;
    localparam int HYST_W      = 12;
    localparam int SCOUNT_W    = 11;
    localparam int MULB_W      = 17;    // multiplier B operand, holds -bend_low
    localparam int PROD_W      = BOUND_W + MULB_W;

    // Configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_ADDR_W-1:0] REG_ADC_BITS     = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_BEND_LOW     = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_BEND_HIGH    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_HYSTERESIS   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_SAMPLE_COUNT = 3'd4;

    // Which way the current beat is processed
    typedef enum logic [1:0] {
        KIND_CAL,
        KIND_ZERO,
        KIND_BELOW,
        KIND_ABOVE
    } kind_t;

    typedef struct packed {
        logic  load;        // capture and clamp input sample
        logic  cal_acc;     // add sample to calibration sum
        logic  cal_fin;     // derive bounds from quotient
        logic  mul;         // register product
        logic  div_start;   // load divider
        logic  div_cal;     // divider source: calibration sum / count
        logic  div_step;    // one restoring step
        logic  out_load;    // load output register, commit last reading
        kind_t kind;
    } dzam_cmd_t;

    typedef struct packed {
        logic cal_done;
        logic below;
        logic above;
        logic seen_reached;
    } dzam_status_t;

endpackage

@@ design/dzam_datapath.sv @@
// Datapath: config registers, calibration accumulator, multiplier,
// restoring divider and output register. Depends on dzam_pkg.
module dzam_datapath #(
    parameter int SAMPLE_WIDTH    = 16,
    parameter int MAX_CAL_SAMPLES = 1024,
    parameter int DIV_W           = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [dzam_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [dzam_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic [dzam_pkg::IN_DATA_W-1:0]      s_sample,
    input  dzam_pkg::dzam_cmd_t                 cmd,
    output dzam_pkg::dzam_status_t              status,
    output logic signed [dzam_pkg::READING_W-1:0] reading,
    output logic                                changed,
    output logic                                calibrating,
    output logic signed [dzam_pkg::BOUND_W-1:0] deadzone_floor,
    output logic signed [dzam_pkg::BOUND_W-1:0] deadzone_ceiling
);
    import dzam_pkg::*;

    localparam int CNT_W  = $clog2(MAX_CAL_SAMPLES + 1);
    localparam int SUM_W  = SAMPLE_WIDTH + CNT_W;
    localparam int DVS_W  = (SAMPLE_WIDTH > CNT_W) ? SAMPLE_WIDTH : CNT_W;
    localparam int NCMP_W = (CNT_W > SCOUNT_W) ? CNT_W : SCOUNT_W;

    // Config
    logic [ADC_BITS_W-1:0]         adc_bits_reg;
    logic signed [BEND_LOW_W-1:0]  bend_low_reg;
    logic [BEND_HIGH_W-1:0]        bend_high_reg;
    logic [HYST_W-1:0]             hyst_reg;
    logic [SCOUNT_W-1:0]           scount_reg;

    // Model state
    logic [SUM_W-1:0]              sum_reg;
    logic [CNT_W-1:0]              seen_reg;
    logic                          cal_done_reg;
    logic signed [BOUND_W-1:0]     floor_reg;
    logic signed [BOUND_W-1:0]     ceil_reg;
    logic signed [READING_W-1:0]   last_reg;

    // Working registers
    logic [SAMPLE_WIDTH-1:0]       value_reg;
    logic signed [PROD_W-1:0]      prod_reg;
    logic [DIV_W-1:0]              quo_reg;
    logic [DVS_W-1:0]              rem_reg;
    logic [DVS_W-1:0]              dvs_reg;
    logic                          neg_reg;

    // Output register
    logic signed [READING_W-1:0]   reading_reg;
    logic                          changed_reg;
    logic                          calibrating_reg;
    logic signed [BOUND_W-1:0]     floor_out_reg;
    logic signed [BOUND_W-1:0]     ceil_out_reg;

    // Full scale from effective resolution
    logic [ADC_BITS_W-1:0]         bits_eff;
    logic [SAMPLE_WIDTH:0]         ones_shift;
    logic [SAMPLE_WIDTH-1:0]       full_w;
    logic [SAMPLE_WIDTH-1:0]       samp_w;

    always_comb begin
        if (adc_bits_reg == '0) begin
            bits_eff = ADC_BITS_W'(1);
        end else if (adc_bits_reg > ADC_BITS_W'(SAMPLE_WIDTH)) begin
            bits_eff = ADC_BITS_W'(SAMPLE_WIDTH);
        end else begin
            bits_eff = adc_bits_reg;
        end
    end

    assign ones_shift = {(SAMPLE_WIDTH+1){1'b1}} << bits_eff;
    assign full_w     = ~ones_shift[SAMPLE_WIDTH-1:0];
    assign samp_w     = s_sample[SAMPLE_WIDTH-1:0];

    // Compare and difference terms
    logic signed [BOUND_W-1:0] val_ext;
    logic signed [BOUND_W-1:0] full_ext;
    logic signed [BOUND_W-1:0] hyst_ext;
    logic signed [BOUND_W-1:0] bl_ext;
    logic signed [BOUND_W-1:0] val_minus_ceil;
    logic signed [BOUND_W-1:0] full_minus_ceil;

    assign val_ext         = $signed({{(BOUND_W-SAMPLE_WIDTH){1'b0}}, value_reg});
    assign full_ext        = $signed({{(BOUND_W-SAMPLE_WIDTH){1'b0}}, full_w});
    assign hyst_ext        = $signed({{(BOUND_W-HYST_W){1'b0}}, hyst_reg});
    assign bl_ext          = BOUND_W'(bend_low_reg);
    assign val_minus_ceil  = val_ext - ceil_reg;
    assign full_minus_ceil = full_ext - ceil_reg;

    // Effective calibration count
    logic [NCMP_W-1:0] n_eff;
    logic [NCMP_W-1:0] scount_ext;

    assign scount_ext = NCMP_W'(scount_reg);

    always_comb begin
        if (scount_reg == '0) begin
            n_eff = NCMP_W'(1);
        end else if (scount_ext > NCMP_W'(MAX_CAL_SAMPLES)) begin
            n_eff = NCMP_W'(MAX_CAL_SAMPLES);
        end else begin
            n_eff = scount_ext;
        end
    end

    assign status.cal_done     = cal_done_reg;
    assign status.below        = val_ext < floor_reg;
    assign status.above        = val_ext > ceil_reg;
    assign status.seen_reached = NCMP_W'(seen_reg) >= n_eff;

    // Multiplier operands
    logic signed [BOUND_W-1:0] op_a;
    logic signed [MULB_W-1:0]  op_b;
    logic signed [MULB_W-1:0]  bl_m;
    logic signed [PROD_W-1:0]  prod_w;
    logic [PROD_W-1:0]         prod_mag;

    assign bl_m = MULB_W'(bend_low_reg);

    always_comb begin
        if (cmd.kind == KIND_BELOW) begin
            op_a = val_ext;
            op_b = -bl_m;
        end else begin
            op_a = val_minus_ceil;
            op_b = $signed({{(MULB_W-BEND_HIGH_W){1'b0}}, bend_high_reg});
        end
    end

    assign prod_w   = op_a * op_b;
    assign prod_mag = prod_reg[PROD_W-1] ? PROD_W'(-prod_reg) : PROD_W'(prod_reg);

    // Divider start operands and step
    logic [DIV_W-1:0] dividend_w;
    logic [DVS_W-1:0] divisor_w;
    logic [DVS_W:0]   rem_sh;
    logic             rem_ge;
    logic [DVS_W:0]   rem_sub;

    always_comb begin
        if (cmd.div_cal) begin
            dividend_w = DIV_W'(sum_reg);
            divisor_w  = DVS_W'(seen_reg);
        end else begin
            dividend_w = prod_mag[DIV_W-1:0];
            if (cmd.kind == KIND_BELOW) begin
                divisor_w = floor_reg[DVS_W-1:0];
            end else begin
                divisor_w = full_minus_ceil[DVS_W-1:0];
            end
        end
    end

    assign rem_sh  = {rem_reg, quo_reg[DIV_W-1]};
    assign rem_ge  = rem_sh >= {1'b0, dvs_reg};
    assign rem_sub = rem_sh - {1'b0, dvs_reg};

    // Result
    logic signed [BOUND_W-1:0]   q_ext;
    logic signed [BOUND_W-1:0]   q_s;
    logic signed [BOUND_W-1:0]   reading_full;
    logic signed [READING_W-1:0] reading_w;
    logic                        changed_w;
    logic signed [BOUND_W-1:0]   avg_ext;

    assign q_ext   = $signed({{(BOUND_W-READING_W-1){1'b0}}, quo_reg[READING_W:0]});
    assign q_s     = neg_reg ? -q_ext : q_ext;
    assign avg_ext = $signed({{(BOUND_W-SAMPLE_WIDTH){1'b0}}, quo_reg[SAMPLE_WIDTH-1:0]});

    always_comb begin
        unique case (cmd.kind)
            KIND_BELOW: reading_full = q_s + bl_ext;
            KIND_ABOVE: reading_full = q_s;
            default:    reading_full = '0;
        endcase
    end

    assign reading_w = reading_full[READING_W-1:0];
    assign changed_w = (cmd.kind != KIND_CAL) && (reading_w != last_reg);

    // State with reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            adc_bits_reg  <= ADC_BITS_W'(12);
            bend_low_reg  <= BEND_LOW_W'(-8192);
            bend_high_reg <= BEND_HIGH_W'(8191);
            hyst_reg      <= HYST_W'(100);
            scount_reg    <= SCOUNT_W'(100);
            sum_reg       <= '0;
            seen_reg      <= '0;
            cal_done_reg  <= 1'b0;
            floor_reg     <= '0;
            ceil_reg      <= '0;
            last_reg      <= '0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_addr)
                    REG_ADC_BITS:     adc_bits_reg  <= cfg_wdata[ADC_BITS_W-1:0];
                    REG_BEND_LOW:     bend_low_reg  <= $signed(cfg_wdata[BEND_LOW_W-1:0]);
                    REG_BEND_HIGH:    bend_high_reg <= cfg_wdata[BEND_HIGH_W-1:0];
                    REG_HYSTERESIS:   hyst_reg      <= cfg_wdata[HYST_W-1:0];
                    REG_SAMPLE_COUNT: scount_reg    <= cfg_wdata[SCOUNT_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.cal_acc) begin
                sum_reg  <= sum_reg + SUM_W'(value_reg);
                seen_reg <= seen_reg + CNT_W'(1);
            end
            if (cmd.cal_fin) begin
                floor_reg    <= avg_ext - hyst_ext;
                ceil_reg     <= avg_ext + hyst_ext;
                cal_done_reg <= 1'b1;
            end
            if (cmd.out_load && (cmd.kind != KIND_CAL)) begin
                last_reg <= reading_w;
            end
        end
    end

    // Payload, no reset
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            value_reg <= (samp_w > full_w) ? full_w : samp_w;
        end
        if (cmd.mul) begin
            prod_reg <= prod_w;
        end
        if (cmd.div_start) begin
            quo_reg <= dividend_w;
            rem_reg <= '0;
            dvs_reg <= divisor_w;
            neg_reg <= cmd.div_cal ? 1'b0 : prod_reg[PROD_W-1];
        end else if (cmd.div_step) begin
            quo_reg <= {quo_reg[DIV_W-2:0], rem_ge};
            rem_reg <= rem_ge ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
        end
        if (cmd.out_load) begin
            reading_reg     <= (cmd.kind == KIND_CAL) ? '0 : reading_w;
            changed_reg     <= changed_w;
            calibrating_reg <= (cmd.kind == KIND_CAL);
            floor_out_reg   <= floor_reg;
            ceil_out_reg    <= ceil_reg;
        end
    end

    assign reading          = reading_reg;
    assign changed          = changed_reg;
    assign calibrating      = calibrating_reg;
    assign deadzone_floor   = floor_out_reg;
    assign deadzone_ceiling = ceil_out_reg;

endmodule

@@ design/dzam_ctrl.sv @@
// Controller FSM: sequences calibration, multiply, serial divide and output.
// Depends on dzam_pkg; drives dzam_datapath through dzam_cmd_t.
module dzam_ctrl #(
    parameter int DIV_W = 32
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    input  dzam_pkg::dzam_status_t status,
    output dzam_pkg::dzam_cmd_t    cmd
);
    import dzam_pkg::*;

    localparam int STEP_W = $clog2(DIV_W);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_CAL_CHECK,
        ST_MUL,
        ST_DIV_START,
        ST_DIV,
        ST_CAL_FIN,
        ST_EMIT
    } state_t;

    state_t            state_reg, state_next;
    kind_t             kind_reg, kind_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              m_valid_reg, m_valid_next;
    logic              accept;
    logic              out_free;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;

    always_comb begin
        state_next = state_reg;
        kind_next  = kind_reg;
        step_next  = step_reg;
        cmd        = '0;
        cmd.kind   = kind_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd.load   = 1'b1;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                priority if (!status.cal_done) begin
                    cmd.cal_acc = 1'b1;
                    kind_next   = KIND_CAL;
                    state_next  = ST_CAL_CHECK;
                end else if (status.below) begin
                    kind_next  = KIND_BELOW;
                    state_next = ST_MUL;
                end else if (status.above) begin
                    kind_next  = KIND_ABOVE;
                    state_next = ST_MUL;
                end else begin
                    kind_next  = KIND_ZERO;
                    state_next = ST_EMIT;
                end
            end
            ST_CAL_CHECK: begin
                if (status.seen_reached) begin
                    cmd.div_start = 1'b1;
                    cmd.div_cal   = 1'b1;
                    step_next     = '0;
                    state_next    = ST_DIV;
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_DIV_START;
            end
            ST_DIV_START: begin
                cmd.div_start = 1'b1;
                step_next     = '0;
                state_next    = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(DIV_W - 1)) begin
                    state_next = (kind_reg == KIND_CAL) ? ST_CAL_FIN : ST_EMIT;
                end
            end
            ST_CAL_FIN: begin
                cmd.cal_fin = 1'b1;
                state_next  = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        m_valid_next = m_valid_reg && !m_axis_tready;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            kind_reg    <= KIND_CAL;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            kind_reg    <= kind_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

`ifndef SYNTHESIS
    // Never overwrite a beat the sink has not taken
    a_out_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid_reg || m_axis_tready))
        else $error("output register overwritten while full");

    // One item in flight: input closes right after a beat is taken
    a_accept_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_axis_tready)
        else $error("input ready while item in flight");

    // Output valid only rises from the emit step
    a_valid_from_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_EMIT))
        else $error("output valid raised outside emit");

    // Divider runs exactly DIV_W steps
    a_div_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.div_step && step_reg == STEP_W'(DIV_W - 1)) |=> !cmd.div_step)
        else $error("divider ran past its last step");
`endif

endmodule

@@ design/deadzone_axis_mapper_core.sv @@
// Deadzone axis mapper top level: controller plus datapath, stream ports.
// Accept to m_axis_tvalid: a deadzone beat goes EVAL, EMIT; a calibration beat EVAL,
// CAL_CHECK, EMIT; a mapped sample EVAL, MUL, DIV_START, DIV, EMIT; the last calibration
// beat EVAL, CAL_CHECK, DIV, CAL_FIN, EMIT. One item in flight, next beat accepted the cycle
// after the result is loaded; the DIV_W-step restoring divider dominates the time per item.
// aresetn is synchronous, active low: registers to defaults, calibration starts over.
module deadzone_axis_mapper_core #(
    parameter int SAMPLE_WIDTH    = 16,
    parameter int MAX_CAL_SAMPLES = 1024
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Configuration write port
    input  logic                                cfg_we,
    input  logic [dzam_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [dzam_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    // Sample input
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [dzam_pkg::IN_DATA_W-1:0]      s_axis_tdata,   // [15:0] sample
    // Result output
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [15:0] reading, [33:16] deadzone_floor, [51:34] deadzone_ceiling, [55:52] zero
    output logic [dzam_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // [0] changed, [1] calibrating
    output logic [dzam_pkg::OUT_USER_W-1:0]     m_axis_tuser
);
    import dzam_pkg::*;

    // Divider dividend width: product of a sample and a 16-bit bend limit
    localparam int DIV_W = SAMPLE_WIDTH + 16;

    dzam_cmd_t                   cmd;
    dzam_status_t                status;
    logic signed [READING_W-1:0] reading;
    logic                        changed;
    logic                        calibrating;
    logic signed [BOUND_W-1:0]   dz_floor;
    logic signed [BOUND_W-1:0]   dz_ceiling;

    dzam_ctrl #(
        .DIV_W (DIV_W)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .status        (status),
        .cmd           (cmd)
    );

    dzam_datapath #(
        .SAMPLE_WIDTH    (SAMPLE_WIDTH),
        .MAX_CAL_SAMPLES (MAX_CAL_SAMPLES),
        .DIV_W           (DIV_W)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_addr         (cfg_addr),
        .cfg_wdata        (cfg_wdata),
        .s_sample         (s_axis_tdata),
        .cmd              (cmd),
        .status           (status),
        .reading          (reading),
        .changed          (changed),
        .calibrating      (calibrating),
        .deadzone_floor   (dz_floor),
        .deadzone_ceiling (dz_ceiling)
    );

    // Beat packing, first field lowest
    assign m_axis_tdata = {{(OUT_DATA_W - READING_W - 2*BOUND_W){1'b0}},
                           dz_ceiling, dz_floor, reading};
    assign m_axis_tuser = {calibrating, changed};

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking bench for deadzone_axis_mapper_core: directed table, then random sample phases.
// Needs dzam_pkg and the core RTL; each beat is checked against a table entry or a predictor.
module testbench;
    import dzam_pkg::*;

    localparam int SAMPLE_W     = 16;
    localparam int MAX_CAL      = 1024;
    localparam int PHASES       = 8;
    localparam int PHASE_BEATS  = 60;
    localparam int DRAIN_CYCLES = 40;
    // Worst beat: the longest input gap, the mapping work and the longest output stall; about 500
    // beats plus register writes, and the limit leaves ample margin.
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic signed [READING_W-1:0] reading;
        logic                        changed;
        logic                        calibrating;
        logic signed [BOUND_W-1:0]   dz_floor;
        logic signed [BOUND_W-1:0]   dz_ceiling;
    } axis_result_t;

    typedef enum logic { OP_WRITE, OP_SAMPLE } row_op_t;

    typedef struct packed {
        row_op_t               op;
        logic [CFG_ADDR_W-1:0] reg_idx;   // unused on sample rows
        logic [CFG_DATA_W-1:0] value;     // register data or sample
        logic                  typed;     // want holds a hand-worked result
        axis_result_t          want;
    } script_row_t;

    localparam axis_result_t NO_RESULT = '0;
    localparam axis_result_t CAL_ZERO  = '{16'sd0, 1'b0, 1'b1, 18'sd0, 18'sd0};
    // Calibration beats 0, 4095 (clamped), 2000, 2100, 2049: sum 10244 / 5 = 2048,
    // so with hysteresis 150 the deadzone is 1898..2198.
    localparam logic signed [BOUND_W-1:0] DZ_LO = 18'sd1898;
    localparam logic signed [BOUND_W-1:0] DZ_HI = 18'sd2198;

    localparam int SCRIPT_LEN = 37;
    localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
        // count above the maximum saturates, so calibration runs on
        '{OP_WRITE,  REG_SAMPLE_COUNT, 16'd2047,  1'b0, NO_RESULT},
        '{OP_WRITE,  REG_HYSTERESIS,   16'd150,   1'b0, NO_RESULT},
        '{OP_SAMPLE, REG_ADC_BITS,     16'd0,     1'b1, CAL_ZERO},
        '{OP_SAMPLE, REG_ADC_BITS,     16'hFFFF,  1'b1, CAL_ZERO},
        '{OP_SAMPLE, REG_ADC_BITS,     16'd2000,  1'b1, CAL_ZERO},
        '{OP_SAMPLE, REG_ADC_BITS,     16'd2100,  1'b1, CAL_ZERO},
        // count dropped to zero, below beats already seen: next beat closes calibration
        '{OP_WRITE,  REG_SAMPLE_COUNT, 16'd0,     1'b0, NO_RESULT},
        '{OP_SAMPLE, REG_ADC_BITS,     16'd2049,  1'b1, '{16'sd0, 1'b0, 1'b1, DZ_LO, DZ_HI}},
        '{OP_SAMPLE, REG_ADC_BITS,     16'd2048,  1'b1, '{16'sd0, 1'b0, 1'b0, DZ_LO, DZ_HI}},
        '{OP_SAMPLE, REG_ADC_BITS,     16'd0,     1'b1,
            '{-16'sd8192, 1'b1, 1'b0, DZ_LO, DZ_HI}},
        '{OP_SAMPLE, REG_ADC_BITS,     16'd4095,  1'b1, '{16'sd8191, 1'b1, 1'b0, DZ_LO, DZ_HI}},
        // above full scale clamps, same reading so no change
        '{OP_SAMPLE, REG_ADC_BITS,     16'hFFFF,  1'b1, '{16'sd8191, 1'b0, 1'b0, DZ_LO, DZ_HI}},
        '{OP_SAMPLE, REG_ADC_BITS,     16'd1898,  1'b1, '{16'sd0, 1'b1, 1'b0, DZ_LO, DZ_HI}},
        '{OP_SAMPLE, REG_ADC_BITS,     16'd2198,  1'b1, '{16'sd0, 1'b0, 1'b0, DZ_LO, DZ_HI}},
        '{OP_SAMPLE, REG_ADC_BITS,     16'd1897,  1'b0, NO_RESULT},
        '{OP_SAMPLE, REG_ADC_BITS,     16'd2199,  1'b0, NO_RESULT},
        '{OP_WRITE,  REG_BEND_LOW,     16'h8000,  1'b0, NO_RESULT},
        '{OP_WRITE,  REG_BEND_HIGH,    16'h7FFF,  1'b0, NO_RESULT},
        '{OP_SAMPLE, REG_ADC_BITS,     16'd0,     1'b1, '{16'sh8000, 1'b1, 1'b0, DZ_LO, DZ_HI}},
        '{OP_SAMPLE, REG_ADC_BITS,     16'd4095,  1'b1, '{16'sd32767, 1'b1, 1'b0, DZ_LO, DZ_HI}},
        // positive low bend limit: wrong sign, same formula
        '{OP_WRITE,  REG_BEND_LOW,     16'h7FFF,  1'b0, NO_RESULT},
        '{OP_SAMPLE, REG_ADC_BITS,     16'd1000,  1'b0, NO_RESULT},
        // zero resolution acts as one bit
        '{OP_WRITE,  REG_ADC_BITS,     16'd0,     1'b0, NO_RESULT},
        '{OP_SAMPLE, REG_ADC_BITS,     16'hFFFF,  1'b0, NO_RESULT},
        // resolution beyond the sample width saturates to 16 bits
        '{OP_WRITE,  REG_ADC_BITS,     16'd31,    1'b0, NO_RESULT},
        '{OP_SAMPLE, REG_ADC_BITS,     16'hFFFF,  1'b1, '{16'sd32767, 1'b1, 1'b0, DZ_LO, DZ_HI}},
        '{OP_WRITE,  REG_BEND_LOW,     16'd0,     1'b0, NO_RESULT},
        '{OP_WRITE,  REG_BEND_HIGH,    16'd0,     1'b0, NO_RESULT},
        '{OP_SAMPLE, REG_ADC_BITS,     16'd0,     1'b1, '{16'sd0, 1'b1, 1'b0, DZ_LO, DZ_HI}},
        '{OP_SAMPLE, REG_ADC_BITS,     16'hFFFF,  1'b1, '{16'sd0, 1'b0, 1'b0, DZ_LO, DZ_HI}},
        '{OP_WRITE,  REG_ADC_BITS,     16'd12,    1'b0, NO_RESULT},
        '{OP_WRITE,  REG_BEND_LOW,     16'hE000,  1'b0, NO_RESULT},
        '{OP_WRITE,  REG_BEND_HIGH,    16'd8191,  1'b0, NO_RESULT},
        // bounds are fixed once calibrated; these writes must not move them
        '{OP_WRITE,  REG_HYSTERESIS,   16'd4095,  1'b0, NO_RESULT},
        '{OP_WRITE,  REG_HYSTERESIS,   16'd0,     1'b0, NO_RESULT},
        '{OP_WRITE,  REG_SAMPLE_COUNT, 16'd1024,  1'b0, NO_RESULT},
        '{OP_SAMPLE, REG_ADC_BITS,     16'd1500,  1'b0, NO_RESULT}
    };

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;    // [15:0] sample
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    // [15:0] reading, [33:16] deadzone_floor, [51:34] deadzone_ceiling, [55:52] zero
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [OUT_USER_W-1:0] m_axis_tuser;    // [0] changed, [1] calibrating

    deadzone_axis_mapper_core #(
        .SAMPLE_WIDTH    (SAMPLE_W),
        .MAX_CAL_SAMPLES (MAX_CAL)
    ) u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Mirror of the register file, at reset values
    logic [ADC_BITS_W-1:0]         adc_bits_r  = 5'd12;
    logic signed [BEND_LOW_W-1:0]  bend_low_r  = -16'sd8192;
    logic [BEND_HIGH_W-1:0]        bend_high_r = 15'd8191;
    logic [HYST_W-1:0]             hyst_r      = 12'd100;
    logic [SCOUNT_W-1:0]           count_r     = 11'd100;

    // Mapper state
    longint cal_total    = 0;
    longint cal_taken    = 0;
    bit     centered     = 1'b0;
    longint dz_lo        = 0;
    longint dz_hi        = 0;
    longint prev_reading = 0;

    axis_result_t pending_readings[$];
    int     mismatches = 0;
    int     beats_seen = 0;
    longint cycles     = 0;
    bit     feed_live  = 1'b0;    // s_axis_tvalid currently driven high
    bit     cfg_live   = 1'b0;    // cfg_we currently driven high
    bit     steady     = 1'b0;    // no gaps and no stalls in this stretch

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic longint full_scale();
        int b;
        b = adc_bits_r;
        if (b < 1) b = 1;
        if (b > SAMPLE_W) b = SAMPLE_W;
        return (longint'(1) << b) - 1;
    endfunction

    // Expected result of one accepted sample beat; advances the mapper state.
    function automatic axis_result_t map_sample(input logic [IN_DATA_W-1:0] smp);
        longint full, v, n, avg, bl, bh, hy, reading;
        axis_result_t res;
        full    = full_scale();
        v       = longint'(smp);
        reading = 0;
        res     = '0;
        if (v > full) v = full;
        if (!centered) begin
            n = count_r;
            if (n < 1) n = 1;
            if (n > MAX_CAL) n = MAX_CAL;
            cal_total += v;
            cal_taken += 1;
            if (cal_taken >= n) begin
                avg      = cal_total / cal_taken;
                hy       = hyst_r;
                dz_lo    = avg - hy;
                dz_hi    = avg + hy;
                centered = 1'b1;
            end
            res.calibrating = 1'b1;
        end else begin
            bl = bend_low_r;
            bh = bend_high_r;
            // both divisors are positive here; SV division truncates toward zero
            if (v < dz_lo) begin
                reading = (v * -bl) / dz_lo + bl;
            end else if (v > dz_hi) begin
                reading = ((v - dz_hi) * bh) / (full - dz_hi);
            end
            if (reading != prev_reading) begin
                res.changed  = 1'b1;
                prev_reading = reading;
            end
        end
        res.reading    = reading[READING_W-1:0];
        res.dz_floor   = dz_lo[BOUND_W-1:0];
        res.dz_ceiling = dz_hi[BOUND_W-1:0];
        return res;
    endfunction

    function automatic void flag(input string msg);
        mismatches++;
        if (mismatches <= 10) $display("%s", msg);
    endfunction

    // Idle gap before a beat: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Random sample, weighted toward the deadzone edges and the clamp
    function automatic logic [IN_DATA_W-1:0] pick_sample(input logic [IN_DATA_W-1:0] prev);
        int     r;
        longint full;
        full = full_scale();
        r    = $urandom_range(0, 99);
        if (r < 12) return prev;
        if (r < 27) return 16'(dz_lo - 4 + $urandom_range(0, 8));
        if (r < 42) return 16'(dz_hi - 4 + $urandom_range(0, 8));
        if (r < 57) return 16'($urandom);
        if (r < 62) return 16'd0;
        if (r < 67) return 16'(full);
        if (r < 70) return 16'hFFFF;
        return 16'($urandom_range(0, 32'(full)));
    endfunction

    // Hold off until every expected beat has come back
    task automatic drain();
        if (feed_live) begin
            s_axis_tvalid <= 1'b0;
            feed_live = 1'b0;
        end
        while (pending_readings.size() != 0) @(posedge aclk);
    endtask

    // cfg_we stays high into the next write; the next sample beat lowers it
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        drain();
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= d;
        cfg_live  = 1'b1;
        case (idx)
            REG_ADC_BITS:     adc_bits_r  = d[ADC_BITS_W-1:0];
            REG_BEND_LOW:     bend_low_r  = d[BEND_LOW_W-1:0];
            REG_BEND_HIGH:    bend_high_r = d[BEND_HIGH_W-1:0];
            REG_HYSTERESIS:   hyst_r      = d[HYST_W-1:0];
            REG_SAMPLE_COUNT: count_r     = d[SCOUNT_W-1:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic send_sample(input logic [IN_DATA_W-1:0] smp, input bit typed,
                               input axis_result_t want);
        int gap;
        axis_result_t pred;
        gap = pick_gap();
        if (cfg_live) begin
            cfg_we <= 1'b0;
            cfg_live = 1'b0;
        end
        if (gap > 0) begin
            if (feed_live) begin
                s_axis_tvalid <= 1'b0;
                feed_live = 1'b0;
            end
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= smp;
        feed_live = 1'b1;
        do @(posedge aclk); while (!s_axis_tready);
        pred = map_sample(smp);
        pending_readings.push_back(typed ? want : pred);
    endtask

    task automatic reconfigure();
        int r;
        logic [CFG_DATA_W-1:0] d;
        logic [ADC_BITS_W-1:0] ab;
        r = $urandom_range(0, 99);
        if (r < 8)       ab = '0;
        else if (r < 16) ab = 5'($urandom_range(17, 31));
        else if (r < 30) ab = 5'd16;
        else if (r < 38) ab = 5'd1;
        else if (r < 55) ab = 5'd12;
        else             ab = 5'($urandom_range(2, 15));
        d = 16'($urandom);              // upper bits are don't-care in the register
        d[ADC_BITS_W-1:0] = ab;
        write_reg(REG_ADC_BITS, d);

        r = $urandom_range(0, 99);
        if (r < 10)      d = 16'($urandom_range(1, 32767));   // wrong sign
        else if (r < 15) d = 16'h8000;
        else if (r < 20) d = 16'd0;
        else             d = 16'(0 - $urandom_range(1, 32768));
        write_reg(REG_BEND_LOW, d);

        r = $urandom_range(0, 99);
        d = 16'($urandom);
        if (r < 10)      d[BEND_HIGH_W-1:0] = '0;
        else if (r < 20) d[BEND_HIGH_W-1:0] = '1;
        write_reg(REG_BEND_HIGH, d);

        // no effect once calibrated, but the register bits still toggle
        write_reg(REG_HYSTERESIS, 16'($urandom));
        write_reg(REG_SAMPLE_COUNT, 16'($urandom));
    endtask

    // Result side back-pressure
    initial begin : rx_stall
        int hold;
        int r;
        hold = 0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (steady) begin
                m_axis_tready <= 1'b1;
                hold = 0;
            end else if (hold > 0) begin
                hold--;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 60) begin
                    m_axis_tready <= 1'b1;
                    hold = $urandom_range(0, 7);
                end else if (r < 95) begin
                    m_axis_tready <= 1'b0;
                    hold = $urandom_range(0, 3);
                end else begin
                    m_axis_tready <= 1'b0;
                    hold = $urandom_range(20, 60);
                end
            end
        end
    end

    // Result beat checker: values sampled at the edge, before any update lands
    always @(posedge aclk) begin
        axis_result_t got, want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got.reading     = m_axis_tdata[15:0];
            got.dz_floor    = m_axis_tdata[33:16];
            got.dz_ceiling  = m_axis_tdata[51:34];
            got.changed     = m_axis_tuser[0];
            got.calibrating = m_axis_tuser[1];
            if (pending_readings.size() == 0) begin
                flag($sformatf("beat %0d: result with nothing expected, reading %0d",
                               beats_seen, got.reading));
            end else begin
                want = pending_readings.pop_front();
                if (got.reading !== want.reading)
                    flag($sformatf("beat %0d reading: expected %0d, got %0d",
                                   beats_seen, want.reading, got.reading));
                if (got.changed !== want.changed)
                    flag($sformatf("beat %0d changed: expected %0b, got %0b",
                                   beats_seen, want.changed, got.changed));
                if (got.calibrating !== want.calibrating)
                    flag($sformatf("beat %0d calibrating: expected %0b, got %0b",
                                   beats_seen, want.calibrating, got.calibrating));
                if (got.dz_floor !== want.dz_floor)
                    flag($sformatf("beat %0d deadzone_floor: expected %0d, got %0d",
                                   beats_seen, want.dz_floor, got.dz_floor));
                if (got.dz_ceiling !== want.dz_ceiling)
                    flag($sformatf("beat %0d deadzone_ceiling: expected %0d, got %0d",
                                   beats_seen, want.dz_ceiling, got.dz_ceiling));
            end
            beats_seen++;
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin : stimulus
        int i;
        int phase;
        logic [IN_DATA_W-1:0] smp;
        logic [IN_DATA_W-1:0] last_smp;
        last_smp = '0;
        aresetn       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        cfg_we        <= 1'b0;
        cfg_addr      <= REG_ADC_BITS;
        cfg_wdata     <= '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: calibration, extremes, clamps, wrong-sign bends
        for (i = 0; i < SCRIPT_LEN; i++) begin
            if (SCRIPT[i].op == OP_WRITE)
                write_reg(SCRIPT[i].reg_idx, SCRIPT[i].value);
            else
                send_sample(SCRIPT[i].value, SCRIPT[i].typed, SCRIPT[i].want);
        end

        // Random phases; each starts from an empty pipe with fresh settings
        for (phase = 0; phase < PHASES; phase++) begin
            drain();
            steady = (phase == 1 || phase == 5);
            reconfigure();
            for (i = 0; i < PHASE_BEATS; i++) begin
                smp = pick_sample(last_smp);
                last_smp = smp;
                send_sample(smp, 1'b0, NO_RESULT);
            end
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && pending_readings.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

@@ deadzone_axis_mapper_core.f @@
design/dzam_pkg.sv
design/dzam_datapath.sv
design/dzam_ctrl.sv
design/deadzone_axis_mapper_core.sv
test/testbench.sv
